>>> rtl/cpts_pkg.sv
// Shared types and constants of the counter-priority task scheduler.
// Holds the command, run-state, error and sequencer codes and the table entry layout.
// No dependencies.
package cpts_pkg;

  localparam int MAX_TASKS_DEF = 16;
  localparam int ID_W          = 8;
  localparam int PRIO_W        = 8;
  localparam int CNT_W         = 8;

  typedef enum logic [1:0] {
    CMD_TICK = 2'd0,
    CMD_ADD  = 2'd1,
    CMD_SET  = 2'd2,
    CMD_NOP  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    RS_RUNNING = 2'd0,
    RS_WAITING = 2'd1,
    RS_BLOCKED = 2'd2,
    RS_ZOMBIE  = 2'd3
  } run_state_t;

  typedef enum logic [1:0] {
    ERR_OK      = 2'd0,
    ERR_FULL    = 2'd1,
    ERR_UNKNOWN = 2'd2
  } err_t;

  typedef struct packed {
    logic [ID_W-1:0]          id;
    logic signed [PRIO_W-1:0] prio;
    logic [CNT_W-1:0]         cnt;
    run_state_t               rs;
  } slot_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ADD,
    ST_FIND_RD,
    ST_FIND_EV,
    ST_ZAP_RD,
    ST_ZAP_EV,
    ST_MOVE,
    ST_RCMP_RD,
    ST_RCMP_EV,
    ST_WIN_RD,
    ST_WIN_EV,
    ST_PREV_RD,
    ST_PREV_EV,
    ST_FIN
  } state_t;

  function automatic logic eligible(run_state_t rs);
    return (rs == RS_RUNNING) || (rs == RS_WAITING);
  endfunction

endpackage

>>> rtl/cpts_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Used for the scheduler's task table. No dependencies.
module cpts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> rtl/counter_priority_task_scheduler_top.sv
// Top level of the counter-priority task scheduler: sequencer, task table and result register.
// Depends on cpts_pkg and cpts_ram.
//
// The block takes one command at a time and returns one result for it. The task table
// sits in a single RAM with one read and one write per cycle, and a small sequencer walks
// it entry by entry (read, then evaluate and write back). An add writes a single entry,
// and a set-state reads entries until it reaches the match. A tick whose current task
// keeps time left ends after one lookup; a tick that reschedules walks the table up to
// four times (lookup, zombie removal, counter recompute, second lookup). A finished
// result waits in the output register, and the next command is taken while it waits.
module counter_priority_task_scheduler_top #(
  parameter int MAX_TASKS = cpts_pkg::MAX_TASKS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        in_cmd,
  input  logic [cpts_pkg::ID_W-1:0]         in_task_id,
  input  logic signed [cpts_pkg::PRIO_W-1:0] in_task_priority,
  input  logic [cpts_pkg::CNT_W-1:0]        in_initial_counter,
  input  logic [1:0]                        in_new_state,
  input  logic                              in_preempt_held,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [cpts_pkg::ID_W-1:0]         out_next_task_id,
  output logic                              out_next_valid,
  output logic                              out_switched,
  output logic [1:0]                        out_error_code
);

  localparam int IW = $clog2(MAX_TASKS);
  localparam int CW = $clog2(MAX_TASKS + 1);
  localparam int SW = $bits(cpts_pkg::slot_t);

  cpts_pkg::state_t                state_r, state_nxt;
  cpts_pkg::cmd_t                  cmd_r, cmd_nxt;
  logic [cpts_pkg::ID_W-1:0]       id_r, id_nxt;
  logic signed [cpts_pkg::PRIO_W-1:0] prio_r, prio_nxt;
  logic [cpts_pkg::CNT_W-1:0]      cinit_r, cinit_nxt;
  cpts_pkg::run_state_t            nst_r, nst_nxt;
  logic                            held_r, held_nxt;
  logic [CW-1:0]                   count_r, count_nxt;
  logic [cpts_pkg::ID_W-1:0]       cur_task_r, cur_task_nxt;
  logic                            cur_valid_r, cur_valid_nxt;
  logic [CW-1:0]                   idx_r, idx_nxt;
  logic                            second_r, second_nxt;
  logic                            cur_found_r, cur_found_nxt;
  logic [IW-1:0]                   cur_idx_r, cur_idx_nxt;
  logic [cpts_pkg::CNT_W-1:0]      best_r, best_nxt;
  logic                            win_found_r, win_found_nxt;
  logic [IW-1:0]                   win_idx_r, win_idx_nxt;
  logic [cpts_pkg::ID_W-1:0]       win_id_r, win_id_nxt;
  logic                            sw_r, sw_nxt;
  cpts_pkg::err_t                  err_r, err_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic [cpts_pkg::ID_W-1:0]       out_id_r, out_id_nxt;
  logic                            out_nv_r, out_nv_nxt;
  logic                            out_sw_r, out_sw_nxt;
  cpts_pkg::err_t                  out_err_r, out_err_nxt;

  logic                            ram_wr_en;
  logic [IW-1:0]                   ram_wr_addr;
  cpts_pkg::slot_t                 ram_wr_data;
  logic                            ram_rd_en;
  logic [IW-1:0]                   ram_rd_addr;
  logic [SW-1:0]                   ram_rd_data;

  cpts_pkg::slot_t                 rd_slot;
  logic                            idx_end;
  logic [IW-1:0]                   idx_a;
  logic [CW-1:0]                   idx_inc;
  logic [CW-1:0]                   count_m1;
  logic [cpts_pkg::ID_W-1:0]       find_tgt;
  logic                            id_hit;
  logic [cpts_pkg::CNT_W-1:0]      dec_cnt;
  logic                            zap_better;
  logic signed [cpts_pkg::CNT_W:0] rc_sum;
  logic [cpts_pkg::CNT_W-1:0]      rc_cnt;
  logic                            rc_better;
  logic                            fin_load;
  logic                            sel_done;

  cpts_ram #(
    .WIDTH(SW),
    .DEPTH(MAX_TASKS)
  ) u_table (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  assign rd_slot   = cpts_pkg::slot_t'(ram_rd_data);
  assign idx_end   = (idx_r >= count_r);
  assign idx_a     = idx_r[IW-1:0];
  assign idx_inc   = idx_r + 1'b1;
  assign count_m1  = count_r - 1'b1;
  assign find_tgt  = (cmd_r == cpts_pkg::CMD_SET) ? id_r : cur_task_r;
  assign id_hit    = (rd_slot.id == find_tgt);
  assign dec_cnt   = (rd_slot.cnt == '0) ? '0 : rd_slot.cnt - 1'b1;
  assign zap_better = cpts_pkg::eligible(rd_slot.rs) && (!win_found_r || rd_slot.cnt > best_r);
  assign rc_sum    = $signed({2'b00, rd_slot.cnt[cpts_pkg::CNT_W-1:1]})
                   + $signed({rd_slot.prio[cpts_pkg::PRIO_W-1], rd_slot.prio});
  assign rc_cnt    = rc_sum[cpts_pkg::CNT_W] ? '0 : rc_sum[cpts_pkg::CNT_W-1:0];
  assign rc_better = cpts_pkg::eligible(rd_slot.rs) && (!win_found_r || rc_cnt > best_r);
  assign fin_load  = (state_r == cpts_pkg::ST_FIN) && (!out_valid_r || out_ready);
  assign sel_done  = win_found_r && (best_r != '0);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      cpts_pkg::ST_IDLE: begin
        if (in_valid) begin
          case (cpts_pkg::cmd_t'(in_cmd))
            cpts_pkg::CMD_TICK: begin
              if (cur_valid_r) state_nxt = cpts_pkg::ST_FIND_RD;
              else if (in_preempt_held) state_nxt = cpts_pkg::ST_FIN;
              else state_nxt = cpts_pkg::ST_ZAP_RD;
            end
            cpts_pkg::CMD_ADD: state_nxt = cpts_pkg::ST_ADD;
            cpts_pkg::CMD_SET: state_nxt = cpts_pkg::ST_FIND_RD;
            default:           state_nxt = cpts_pkg::ST_FIN;
          endcase
        end
      end
      cpts_pkg::ST_ADD: state_nxt = cpts_pkg::ST_FIN;
      cpts_pkg::ST_FIND_RD: begin
        if (!idx_end) state_nxt = cpts_pkg::ST_FIND_EV;
        else if (cmd_r == cpts_pkg::CMD_SET) state_nxt = cpts_pkg::ST_FIN;
        else if (second_r) state_nxt = cpts_pkg::ST_WIN_RD;
        else if (held_r) state_nxt = cpts_pkg::ST_FIN;
        else state_nxt = cpts_pkg::ST_ZAP_RD;
      end
      cpts_pkg::ST_FIND_EV: begin
        if (!id_hit) state_nxt = cpts_pkg::ST_FIND_RD;
        else if (cmd_r == cpts_pkg::CMD_SET) state_nxt = cpts_pkg::ST_FIN;
        else if (second_r) begin
          state_nxt = (idx_a == win_idx_r) ? cpts_pkg::ST_FIN : cpts_pkg::ST_WIN_RD;
        end else begin
          state_nxt = (dec_cnt != '0 || held_r) ? cpts_pkg::ST_FIN : cpts_pkg::ST_ZAP_RD;
        end
      end
      cpts_pkg::ST_ZAP_RD: begin
        if (!idx_end) state_nxt = cpts_pkg::ST_ZAP_EV;
        else if (sel_done) begin
          state_nxt = cur_valid_r ? cpts_pkg::ST_FIND_RD : cpts_pkg::ST_WIN_RD;
        end else state_nxt = cpts_pkg::ST_RCMP_RD;
      end
      cpts_pkg::ST_ZAP_EV: begin
        if (rd_slot.rs == cpts_pkg::RS_ZOMBIE && idx_r < count_m1) state_nxt = cpts_pkg::ST_MOVE;
        else state_nxt = cpts_pkg::ST_ZAP_RD;
      end
      cpts_pkg::ST_MOVE: state_nxt = cpts_pkg::ST_ZAP_EV;
      cpts_pkg::ST_RCMP_RD: begin
        if (!idx_end) state_nxt = cpts_pkg::ST_RCMP_EV;
        else if (win_found_r) begin
          state_nxt = cur_valid_r ? cpts_pkg::ST_FIND_RD : cpts_pkg::ST_WIN_RD;
        end else state_nxt = cpts_pkg::ST_FIN;
      end
      cpts_pkg::ST_RCMP_EV: state_nxt = cpts_pkg::ST_RCMP_RD;
      cpts_pkg::ST_WIN_RD:  state_nxt = cpts_pkg::ST_WIN_EV;
      cpts_pkg::ST_WIN_EV:  state_nxt = cur_found_r ? cpts_pkg::ST_PREV_RD : cpts_pkg::ST_FIN;
      cpts_pkg::ST_PREV_RD: state_nxt = cpts_pkg::ST_PREV_EV;
      cpts_pkg::ST_PREV_EV: state_nxt = cpts_pkg::ST_FIN;
      cpts_pkg::ST_FIN: begin
        if (!out_valid_r || out_ready) state_nxt = cpts_pkg::ST_IDLE;
      end
      default: state_nxt = cpts_pkg::ST_IDLE;
    endcase
  end

  // Table access and datapath updates.
  always_comb begin
    cmd_nxt       = cmd_r;
    id_nxt        = id_r;
    prio_nxt      = prio_r;
    cinit_nxt     = cinit_r;
    nst_nxt       = nst_r;
    held_nxt      = held_r;
    count_nxt     = count_r;
    cur_task_nxt  = cur_task_r;
    cur_valid_nxt = cur_valid_r;
    idx_nxt       = idx_r;
    second_nxt    = second_r;
    cur_found_nxt = cur_found_r;
    cur_idx_nxt   = cur_idx_r;
    best_nxt      = best_r;
    win_found_nxt = win_found_r;
    win_idx_nxt   = win_idx_r;
    win_id_nxt    = win_id_r;
    sw_nxt        = sw_r;
    err_nxt       = err_r;
    out_id_nxt    = out_id_r;
    out_nv_nxt    = out_nv_r;
    out_sw_nxt    = out_sw_r;
    out_err_nxt   = out_err_r;
    out_valid_nxt = out_valid_r && !out_ready;
    ram_wr_en     = 1'b0;
    ram_wr_addr   = idx_a;
    ram_wr_data   = rd_slot;
    ram_rd_en     = 1'b0;
    ram_rd_addr   = idx_a;
    case (state_r)
      cpts_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd_nxt       = cpts_pkg::cmd_t'(in_cmd);
          id_nxt        = in_task_id;
          prio_nxt      = in_task_priority;
          cinit_nxt     = in_initial_counter;
          nst_nxt       = cpts_pkg::run_state_t'(in_new_state);
          held_nxt      = in_preempt_held;
          idx_nxt       = '0;
          second_nxt    = 1'b0;
          cur_found_nxt = 1'b0;
          win_found_nxt = 1'b0;
          best_nxt      = '0;
          sw_nxt        = 1'b0;
          err_nxt       = cpts_pkg::ERR_OK;
        end
      end
      cpts_pkg::ST_ADD: begin
        if (count_r == CW'(MAX_TASKS)) begin
          err_nxt = cpts_pkg::ERR_FULL;
        end else begin
          ram_wr_en        = 1'b1;
          ram_wr_addr      = count_r[IW-1:0];
          ram_wr_data.id   = id_r;
          ram_wr_data.prio = prio_r;
          ram_wr_data.cnt  = cinit_r;
          ram_wr_data.rs   = cpts_pkg::RS_WAITING;
          count_nxt        = count_r + 1'b1;
        end
      end
      cpts_pkg::ST_FIND_RD: begin
        if (!idx_end) begin
          ram_rd_en = 1'b1;
        end else begin
          idx_nxt = '0;
          if (cmd_r == cpts_pkg::CMD_SET) err_nxt = cpts_pkg::ERR_UNKNOWN;
        end
      end
      cpts_pkg::ST_FIND_EV: begin
        if (id_hit) begin
          idx_nxt = '0;
          if (cmd_r == cpts_pkg::CMD_SET) begin
            ram_wr_en      = 1'b1;
            ram_wr_data.rs = nst_r;
          end else if (second_r) begin
            cur_found_nxt = 1'b1;
            cur_idx_nxt   = idx_a;
          end else begin
            ram_wr_en       = 1'b1;
            ram_wr_data.cnt = dec_cnt;
          end
        end else begin
          idx_nxt = idx_inc;
        end
      end
      cpts_pkg::ST_ZAP_RD: begin
        if (!idx_end) begin
          ram_rd_en = 1'b1;
        end else begin
          idx_nxt = '0;
          if (sel_done) second_nxt = 1'b1;
          else win_found_nxt = 1'b0;
        end
      end
      cpts_pkg::ST_ZAP_EV: begin
        if (rd_slot.rs == cpts_pkg::RS_ZOMBIE) begin
          count_nxt = count_m1;
          if (idx_r < count_m1) begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = count_m1[IW-1:0];
          end
        end else begin
          if (zap_better) begin
            best_nxt      = rd_slot.cnt;
            win_idx_nxt   = idx_a;
            win_id_nxt    = rd_slot.id;
            win_found_nxt = 1'b1;
          end
          idx_nxt = idx_inc;
        end
      end
      cpts_pkg::ST_MOVE: begin
        ram_wr_en = 1'b1;
      end
      cpts_pkg::ST_RCMP_RD: begin
        if (!idx_end) begin
          ram_rd_en = 1'b1;
        end else begin
          idx_nxt    = '0;
          second_nxt = 1'b1;
        end
      end
      cpts_pkg::ST_RCMP_EV: begin
        ram_wr_en       = 1'b1;
        ram_wr_data.cnt = rc_cnt;
        if (rc_better) begin
          best_nxt      = rc_cnt;
          win_idx_nxt   = idx_a;
          win_id_nxt    = rd_slot.id;
          win_found_nxt = 1'b1;
        end
        idx_nxt = idx_inc;
      end
      cpts_pkg::ST_WIN_RD: begin
        ram_rd_en   = 1'b1;
        ram_rd_addr = win_idx_r;
      end
      cpts_pkg::ST_WIN_EV: begin
        ram_wr_en      = 1'b1;
        ram_wr_addr    = win_idx_r;
        ram_wr_data.rs = cpts_pkg::RS_RUNNING;
        cur_task_nxt   = win_id_r;
        cur_valid_nxt  = 1'b1;
        sw_nxt         = 1'b1;
      end
      cpts_pkg::ST_PREV_RD: begin
        ram_rd_en   = 1'b1;
        ram_rd_addr = cur_idx_r;
      end
      cpts_pkg::ST_PREV_EV: begin
        ram_wr_addr    = cur_idx_r;
        ram_wr_data.rs = cpts_pkg::RS_WAITING;
        ram_wr_en      = (rd_slot.rs != cpts_pkg::RS_ZOMBIE);
      end
      cpts_pkg::ST_FIN: begin
        if (fin_load) begin
          out_valid_nxt = 1'b1;
          out_id_nxt    = cur_valid_r ? cur_task_r : '0;
          out_nv_nxt    = cur_valid_r;
          out_sw_nxt    = sw_r;
          out_err_nxt   = err_r;
        end
      end
      default: begin
        out_valid_nxt = out_valid_r && !out_ready;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cpts_pkg::ST_IDLE;
      count_r     <= '0;
      cur_task_r  <= '0;
      cur_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      cur_task_r  <= cur_task_nxt;
      cur_valid_r <= cur_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    id_r        <= id_nxt;
    prio_r      <= prio_nxt;
    cinit_r     <= cinit_nxt;
    nst_r       <= nst_nxt;
    held_r      <= held_nxt;
    idx_r       <= idx_nxt;
    second_r    <= second_nxt;
    cur_found_r <= cur_found_nxt;
    cur_idx_r   <= cur_idx_nxt;
    best_r      <= best_nxt;
    win_found_r <= win_found_nxt;
    win_idx_r   <= win_idx_nxt;
    win_id_r    <= win_id_nxt;
    sw_r        <= sw_nxt;
    err_r       <= err_nxt;
    out_id_r    <= out_id_nxt;
    out_nv_r    <= out_nv_nxt;
    out_sw_r    <= out_sw_nxt;
    out_err_r   <= out_err_nxt;
  end

  assign in_ready         = (state_r == cpts_pkg::ST_IDLE);
  assign out_valid        = out_valid_r;
  assign out_next_task_id = out_id_r;
  assign out_next_valid   = out_nv_r;
  assign out_switched     = out_sw_r;
  assign out_error_code   = out_err_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_TASKS))
    else $error("task count exceeds the table size");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    ##1 (count_r == $past(count_r) || count_r == $past(count_r) + 1'b1 ||
         count_r == $past(count_r) - 1'b1))
    else $error("task count changed by more than one in a cycle");

  a_switch_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_sw_r) |-> (out_nv_r && out_err_r == cpts_pkg::ERR_OK))
    else $error("switch reported without a current task or with an error");

  a_idle_id: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_nv_r) |-> (out_id_r == '0))
    else $error("task id reported while no current task exists");

endmodule

>>> dv/counter_priority_task_scheduler_top_test.sv
// Self-checking testbench for the counter-priority task scheduler top level.
// Drives commands with random idling on both channels and checks each result against a built-in
// predictor of the task table. Depends on cpts_pkg and counter_priority_task_scheduler_top.
`timescale 1ns / 1ps

module counter_priority_task_scheduler_top_test;

  localparam int TABLE_DEPTH = cpts_pkg::MAX_TASKS_DEF;
  localparam int PHASE_ITEMS = 310;
  localparam int STALL_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 200;

  typedef struct packed {
    logic [cpts_pkg::ID_W-1:0] task_id;
    logic                      valid;
    logic                      switched;
    cpts_pkg::err_t            err;
  } pick_t;

  class schedule_checker_t;
    logic [cpts_pkg::ID_W-1:0]          slot_id[TABLE_DEPTH];
    logic signed [cpts_pkg::PRIO_W-1:0] slot_prio[TABLE_DEPTH];
    logic [cpts_pkg::CNT_W-1:0]         slot_cnt[TABLE_DEPTH];
    cpts_pkg::run_state_t               slot_rs[TABLE_DEPTH];
    int                                 n_tasks = 0;
    logic [cpts_pkg::ID_W-1:0]          cur_id = '0;
    bit                                 cur_valid = 1'b0;
    pick_t                              expected_picks[$];
    int                                 mismatches = 0;

    function int lookup(logic [cpts_pkg::ID_W-1:0] id);
      for (int i = 0; i < n_tasks; i++) begin
        if (slot_id[i] == id) return i;
      end
      return -1;
    endfunction

    function bit runnable(int i);
      return slot_rs[i] == cpts_pkg::RS_RUNNING || slot_rs[i] == cpts_pkg::RS_WAITING;
    endfunction

    // Removes zombies by pulling the last entry down, then picks the largest counter.
    // Recomputes every counter when no runnable task has time left.
    function int choose_next();
      int best;
      int win;
      int c;
      best = -1;
      win = -1;
      for (int i = 0; i < n_tasks; i++) begin
        while (slot_rs[i] == cpts_pkg::RS_ZOMBIE) begin
          n_tasks--;
          slot_id[i] = slot_id[n_tasks];
          slot_prio[i] = slot_prio[n_tasks];
          slot_cnt[i] = slot_cnt[n_tasks];
          slot_rs[i] = slot_rs[n_tasks];
          if (i >= n_tasks) break;
        end
        if (i < n_tasks && runnable(i) && int'(slot_cnt[i]) > best) begin
          best = int'(slot_cnt[i]);
          win = i;
        end
      end
      if (best <= 0) begin
        best = -1;
        win = -1;
        for (int i = 0; i < n_tasks; i++) begin
          c = int'(slot_cnt[i] >> 1) + int'(slot_prio[i]);
          if (c < 0) c = 0;
          if (c > 255) c = 255;
          slot_cnt[i] = c[cpts_pkg::CNT_W-1:0];
          if (runnable(i) && c > best) begin
            best = c;
            win = i;
          end
        end
      end
      return win;
    endfunction

    function bit run_tick(bit held);
      int cur;
      int left;
      int win;
      cur = cur_valid ? lookup(cur_id) : -1;
      left = 0;
      if (cur >= 0) begin
        if (slot_cnt[cur] != 0) slot_cnt[cur]--;
        left = int'(slot_cnt[cur]);
      end
      if (left > 0 || held) return 1'b0;
      win = choose_next();
      if (win < 0) return 1'b0;
      cur = cur_valid ? lookup(cur_id) : -1;
      if (cur == win) return 1'b0;
      slot_rs[win] = cpts_pkg::RS_RUNNING;
      if (cur >= 0 && slot_rs[cur] != cpts_pkg::RS_ZOMBIE) slot_rs[cur] = cpts_pkg::RS_WAITING;
      cur_id = slot_id[win];
      cur_valid = 1'b1;
      return 1'b1;
    endfunction

    function void note_command(cpts_pkg::cmd_t cmd, logic [cpts_pkg::ID_W-1:0] id,
                               logic signed [cpts_pkg::PRIO_W-1:0] prio,
                               logic [cpts_pkg::CNT_W-1:0] cinit,
                               cpts_pkg::run_state_t nst, bit held);
      pick_t p;
      int s;
      p = '0;
      p.err = cpts_pkg::ERR_OK;
      case (cmd)
        cpts_pkg::CMD_TICK: begin
          p.switched = run_tick(held);
        end
        cpts_pkg::CMD_ADD: begin
          if (n_tasks >= TABLE_DEPTH) begin
            p.err = cpts_pkg::ERR_FULL;
          end else begin
            slot_id[n_tasks] = id;
            slot_prio[n_tasks] = prio;
            slot_cnt[n_tasks] = cinit;
            slot_rs[n_tasks] = cpts_pkg::RS_WAITING;
            n_tasks++;
          end
        end
        cpts_pkg::CMD_SET: begin
          s = lookup(id);
          if (s < 0) p.err = cpts_pkg::ERR_UNKNOWN;
          else slot_rs[s] = nst;
        end
        default: begin
        end
      endcase
      p.task_id = cur_valid ? cur_id : '0;
      p.valid = cur_valid;
      expected_picks.push_back(p);
    endfunction

    function void report(string what, pick_t exp, pick_t got);
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: %s: exp id=%0d v=%0b sw=%0b err=%0d got id=%0d v=%0b sw=%0b err=%0d",
                 $time, what, exp.task_id, exp.valid, exp.switched, exp.err,
                 got.task_id, got.valid, got.switched, got.err);
    endfunction

    function void check_pick(pick_t got);
      pick_t exp;
      if (expected_picks.size() == 0) begin
        report("result with no transfer pending", '0, got);
        return;
      end
      exp = expected_picks.pop_front();
      if (got !== exp) report("result mismatch", exp, got);
    endfunction
  endclass

  logic                               clk;
  logic                               rst_n;
  logic                               in_valid;
  logic                               in_ready;
  logic [1:0]                         in_cmd;
  logic [cpts_pkg::ID_W-1:0]          in_task_id;
  logic signed [cpts_pkg::PRIO_W-1:0] in_task_priority;
  logic [cpts_pkg::CNT_W-1:0]         in_initial_counter;
  logic [1:0]                         in_new_state;
  logic                               in_preempt_held;
  logic                               out_valid;
  logic                               out_ready;
  logic [cpts_pkg::ID_W-1:0]          out_next_task_id;
  logic                               out_next_valid;
  logic                               out_switched;
  logic [1:0]                         out_error_code;

  schedule_checker_t sb = new();
  int send_idle_pct;
  int recv_idle_pct;

  counter_priority_task_scheduler_top #(.MAX_TASKS(TABLE_DEPTH)) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_cmd            (in_cmd),
    .in_task_id        (in_task_id),
    .in_task_priority  (in_task_priority),
    .in_initial_counter(in_initial_counter),
    .in_new_state      (in_new_state),
    .in_preempt_held   (in_preempt_held),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_next_task_id  (out_next_task_id),
    .out_next_valid    (out_next_valid),
    .out_switched      (out_switched),
    .out_error_code    (out_error_code)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  task automatic send_command(cpts_pkg::cmd_t cmd, logic [cpts_pkg::ID_W-1:0] id,
                              logic signed [cpts_pkg::PRIO_W-1:0] prio,
                              logic [cpts_pkg::CNT_W-1:0] cinit, logic [1:0] nst, bit held);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_task_id <= id;
    in_task_priority <= prio;
    in_initial_counter <= cinit;
    in_new_state <= nst;
    in_preempt_held <= held;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_command(cmd, id, prio, cinit, cpts_pkg::run_state_t'(nst), held);
  endtask

  task automatic hold_until_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.expected_picks.size() != 0);
  endtask

  task automatic run_directed();
    send_command(cpts_pkg::CMD_TICK, 8'd0, 8'sd0, 8'd0, cpts_pkg::RS_RUNNING, 1'b0);
    send_command(cpts_pkg::CMD_SET, 8'd200, 8'sd0, 8'd0, cpts_pkg::RS_BLOCKED, 1'b0);
    send_command(cpts_pkg::CMD_NOP, 8'hFF, -8'sd1, 8'hFF, cpts_pkg::RS_ZOMBIE, 1'b1);
    send_command(cpts_pkg::CMD_ADD, 8'd0, -8'sd128, 8'd255, cpts_pkg::RS_ZOMBIE, 1'b0);
    send_command(cpts_pkg::CMD_SET, 8'd0, 8'sd0, 8'd0, cpts_pkg::RS_BLOCKED, 1'b0);
    send_command(cpts_pkg::CMD_ADD, 8'd255, 8'sd127, 8'd0, cpts_pkg::RS_RUNNING, 1'b1);
    send_command(cpts_pkg::CMD_SET, 8'd255, 8'sd0, 8'd0, cpts_pkg::RS_ZOMBIE, 1'b0);
    for (int i = 1; i <= 14; i++)
      send_command(cpts_pkg::CMD_ADD, i[7:0], 8'(i % 5 - 1), 8'(i % 4),
                   cpts_pkg::RS_BLOCKED, 1'b0);
    send_command(cpts_pkg::CMD_ADD, 8'd1, 8'sd3, 8'd3, cpts_pkg::RS_WAITING, 1'b0);
    send_command(cpts_pkg::CMD_TICK, 8'd0, 8'sd0, 8'd0, cpts_pkg::RS_RUNNING, 1'b1);
    send_command(cpts_pkg::CMD_TICK, 8'd0, 8'sd0, 8'd0, cpts_pkg::RS_RUNNING, 1'b0);
    send_command(cpts_pkg::CMD_SET, 8'd1, 8'sd0, 8'd0, cpts_pkg::RS_RUNNING, 1'b0);
    send_command(cpts_pkg::CMD_TICK, 8'd0, 8'sd0, 8'd0, cpts_pkg::RS_RUNNING, 1'b0);
  endtask

  // Mostly well-formed adds, state changes of known tasks and ticks, with some noise.
  task automatic random_command();
    int r;
    int pv;
    cpts_pkg::cmd_t cmd;
    logic [cpts_pkg::ID_W-1:0] id;
    logic signed [cpts_pkg::PRIO_W-1:0] prio;
    logic [cpts_pkg::CNT_W-1:0] cinit;
    logic [1:0] nst;
    bit held;
    r = $urandom_range(99);
    id = 8'($urandom_range(255));
    prio = 8'($urandom_range(255));
    cinit = 8'($urandom_range(255));
    nst = 2'($urandom_range(3));
    held = 1'($urandom_range(1));
    if (r < 5) begin
      cmd = cpts_pkg::cmd_t'($urandom_range(3));
    end else if (r < 33 + (sb.n_tasks < 4 ? 20 : 0)) begin
      cmd = cpts_pkg::CMD_ADD;
      if ($urandom_range(9) != 0) id = 8'($urandom_range(31));
      if ($urandom_range(19) != 0) begin
        pv = int'($urandom_range(10)) - 3;
        prio = pv[cpts_pkg::PRIO_W-1:0];
      end
      if ($urandom_range(99) != 0) cinit = 8'($urandom_range(6));
    end else if (r < 63) begin
      cmd = cpts_pkg::CMD_SET;
      if (sb.n_tasks > 0 && $urandom_range(9) != 0)
        id = sb.slot_id[$urandom_range(sb.n_tasks - 1)];
    end else begin
      cmd = cpts_pkg::CMD_TICK;
      held = ($urandom_range(4) == 0);
    end
    send_command(cmd, id, prio, cinit, nst, held);
  endtask

  initial begin : result_sink
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready)
        sb.check_pick({out_next_task_id, out_next_valid, out_switched,
                       cpts_pkg::err_t'(out_error_code)});
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  initial begin : stimulus
    send_idle_pct = 32;
    recv_idle_pct = 48;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_cmd <= cpts_pkg::CMD_NOP;
    in_task_id <= '0;
    in_task_priority <= '0;
    in_initial_counter <= '0;
    in_new_state <= cpts_pkg::RS_RUNNING;
    in_preempt_held <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    run_directed();
    hold_until_drained();
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 32;
          recv_idle_pct = 48;
        end
        1: begin
          send_idle_pct = 48;
          recv_idle_pct = 32;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      repeat (PHASE_ITEMS) random_command();
      hold_until_drained();
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.expected_picks.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
